>>> hw/rtl/hhi_pkg.sv
package hhi_pkg;

  localparam int P_W    = 17;
  localparam int T_W    = 15;
  localparam int X_W    = 24;
  localparam int H_W    = 28;
  localparam int GAS_W  = 24;
  localparam int CFG_W  = 24;
  localparam int LOG_W  = 37;
  localparam int DIV_W  = 45;
  localparam int NUM_W  = 64;
  localparam int CNT_W  = 7;

  localparam logic [1:0] CFG_DRY    = 2'd0;
  localparam logic [1:0] CFG_VAPOUR = 2'd1;
  localparam logic [1:0] CFG_GRAV   = 2'd2;

  localparam logic [19:0] DRY_RESET    = 20'd287058;
  localparam logic [19:0] VAPOUR_RESET = 20'd461500;
  localparam logic [23:0] GRAV_RESET   = 24'd9806650;

  localparam logic [31:0] LN2_Q32  = 32'd2977044472;
  localparam logic [13:0] SCALE_K  = 14'd15625;
  localparam logic [CNT_W-1:0] GAS_STEPS   = 7'd21;
  localparam logic [CNT_W-1:0] LAYER_STEPS = 7'd62;

  localparam logic signed [H_W-1:0] H_MAX = 28'sh7FFFFFF;
  localparam logic signed [H_W-1:0] H_MIN = -28'sh8000000;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_GAS,
    OP_DIV_GAS,
    OP_LOG_BELOW,
    OP_LOG_CUR,
    OP_MUL_SUM,
    OP_ADD_SUM,
    OP_MUL_K,
    OP_DIV_LAYER,
    OP_MAG,
    OP_LN,
    OP_MUL_HI,
    OP_MUL_LO,
    OP_HEIGHT,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic div_busy;
    logic log_busy;
    logic out_free;
  } status_t;

endpackage

>>> hw/rtl/hypsometric_height_integrator.sv
// One word is in work at a time; the two logarithms run on one squaring unit and
// both divisions run bit-serially on one shared divider (21 and 62 steps).
// A new word is accepted only once the last one has been emitted; a finished result
// waits in the output register, and a result still stalled there delays the next one.
// Synchronous active-low reset clears the column state and restores register defaults.
module hypsometric_height_integrator #(
  parameter int LOG_ITERATIONS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [hhi_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hhi_pkg::P_W-1:0]         in_pressure,
  input  logic [hhi_pkg::T_W-1:0]         in_temperature,
  input  logic [hhi_pkg::X_W-1:0]         in_water_vapour_ratio,
  input  logic                            in_column_start,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [hhi_pkg::H_W-1:0]  out_height_mm,
  output logic                            out_invalid
);

  hhi_pkg::op_t     op;
  hhi_pkg::status_t status;

  hhi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .op       (op)
  );

  hhi_datapath #(
    .LOG_ITERATIONS (LOG_ITERATIONS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .op                    (op),
    .status                (status),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_pressure           (in_pressure),
    .in_temperature        (in_temperature),
    .in_water_vapour_ratio (in_water_vapour_ratio),
    .in_column_start       (in_column_start),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_height_mm         (out_height_mm),
    .out_invalid           (out_invalid)
  );

endmodule

>>> hw/rtl/hhi_divider.sv
module hhi_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [hhi_pkg::DIV_W-1:0]   init_rem,
  input  logic [hhi_pkg::NUM_W-1:0]   init_num,
  input  logic [hhi_pkg::DIV_W-1:0]   divisor,
  input  logic [hhi_pkg::CNT_W-1:0]   steps,
  output logic                        busy,
  output logic [hhi_pkg::NUM_W-1:0]   quotient
);

  logic [hhi_pkg::DIV_W-1:0] rem_r;
  logic [hhi_pkg::DIV_W-1:0] div_r;
  logic [hhi_pkg::NUM_W-1:0] num_r;
  logic [hhi_pkg::NUM_W-1:0] q_r;
  logic [hhi_pkg::CNT_W-1:0] cnt_r;
  logic                      busy_r;
  logic [hhi_pkg::DIV_W:0]   trial;
  logic                      ge;

  assign trial = {rem_r, num_r[hhi_pkg::NUM_W-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= steps;
      rem_r  <= init_rem;
      num_r  <= init_num;
      div_r  <= divisor;
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? hhi_pkg::DIV_W'(trial - {1'b0, div_r}) : trial[hhi_pkg::DIV_W-1:0];
      num_r  <= {num_r[hhi_pkg::NUM_W-2:0], 1'b0};
      q_r    <= {q_r[hhi_pkg::NUM_W-2:0], ge};
      cnt_r  <= cnt_r - 1'b1;
      if (cnt_r == hhi_pkg::CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

>>> hw/rtl/hhi_log2.sv
module hhi_log2 #(
  parameter int LOG_ITERATIONS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [hhi_pkg::P_W-1:0]   value,
  output logic                      busy,
  output logic [hhi_pkg::LOG_W-1:0] result
);

  localparam int CW = $clog2(LOG_ITERATIONS);

  logic [31:0]   m_r;
  logic [31:0]   frac_r;
  logic [4:0]    e_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [4:0]    lead;
  logic [63:0]   sq;
  logic [32:0]   sq_t;
  logic [4:0]    bit_idx;

  always_comb begin
    lead = 5'd0;
    for (int i = 0; i < hhi_pkg::P_W; i++) begin
      if (value[i]) begin
        lead = 5'(i);
      end
    end
  end

  assign sq      = 64'(m_r) * 64'(m_r);
  assign sq_t    = sq[63:31];
  assign bit_idx = 5'(5'd31 - 5'(cnt_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      e_r    <= lead;
      m_r    <= 32'({15'b0, value} << (5'd31 - lead));
      frac_r <= '0;
    end else if (busy_r) begin
      if (sq_t[32]) begin
        m_r             <= sq_t[32:1];
        frac_r[bit_idx] <= 1'b1;
      end else begin
        m_r <= sq_t[31:0];
      end
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(LOG_ITERATIONS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy   = busy_r;
  assign result = {e_r, frac_r};

endmodule

>>> hw/rtl/hhi_datapath.sv
module hhi_datapath #(
  parameter int LOG_ITERATIONS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  hhi_pkg::op_t                    op,
  output hhi_pkg::status_t                status,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [hhi_pkg::CFG_W-1:0]       cfg_data,
  input  logic [hhi_pkg::P_W-1:0]         in_pressure,
  input  logic [hhi_pkg::T_W-1:0]         in_temperature,
  input  logic [hhi_pkg::X_W-1:0]         in_water_vapour_ratio,
  input  logic                            in_column_start,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [hhi_pkg::H_W-1:0]  out_height_mm,
  output logic                            out_invalid
);

  logic [19:0] rd_r, rv_r;
  logic [23:0] g_r;

  logic [hhi_pkg::P_W-1:0] p_r;
  logic [hhi_pkg::T_W-1:0] t_r;
  logic [hhi_pkg::X_W-1:0] x_r;
  logic                    start_r;

  logic [hhi_pkg::GAS_W-1:0]     bgas_r;
  logic [hhi_pkg::T_W-1:0]       btemp_r;
  logic [hhi_pkg::P_W-1:0]       bpres_r;
  logic signed [hhi_pkg::H_W-1:0] bh_r;

  logic [39:0] rdrv_r;
  logic [44:0] dena_r;
  logic [43:0] denb_r;
  logic        den_zero_r;
  logic [hhi_pkg::GAS_W-1:0] gas_r;
  logic [hhi_pkg::LOG_W-1:0] lb_r, lc_r, mag_r;
  logic        neg_r;
  logic [38:0] pa_r, pb_r;
  logic [39:0] sum_r;
  logic [53:0] nk_r;
  logic [61:0] c_r;
  logic [28:0] ln_r;
  logic [60:0] a_r;
  logic [58:0] b_r;
  logic signed [hhi_pkg::H_W-1:0] h_r;
  logic        bad_r;
  logic        out_valid_r;
  logic signed [hhi_pkg::H_W-1:0] out_h_r;
  logic        out_bad_r;

  logic [hhi_pkg::DIV_W-1:0] den_sum;
  logic [23:0]               g_eff;
  logic                      div_start;
  logic [hhi_pkg::DIV_W-1:0] div_rem;
  logic [hhi_pkg::NUM_W-1:0] div_num;
  logic [hhi_pkg::DIV_W-1:0] div_den;
  logic [hhi_pkg::CNT_W-1:0] div_steps;
  logic                      div_busy;
  logic [hhi_pkg::NUM_W-1:0] div_q;
  logic                      log_start;
  logic [hhi_pkg::P_W-1:0]   log_value;
  logic                      log_busy;
  logic [hhi_pkg::LOG_W-1:0] log_result;
  logic [60:0]               ln_prod;
  logic [60:0]               inner;
  logic [59:0]               dz;
  logic [28:0]               dzc;
  logic signed [29:0]        dmag, dsig, hsum;
  logic signed [hhi_pkg::H_W-1:0] h_nxt;
  logic                      bad_nxt;

  assign den_sum   = hhi_pkg::DIV_W'(dena_r) + hhi_pkg::DIV_W'(denb_r);
  assign g_eff     = (g_r == 24'd0) ? 24'd1 : g_r;
  assign div_start = (op == hhi_pkg::OP_DIV_GAS) || (op == hhi_pkg::OP_DIV_LAYER);

  always_comb begin
    if (op == hhi_pkg::OP_DIV_GAS) begin
      div_rem   = hhi_pkg::DIV_W'({rdrv_r, 3'b000});
      div_num   = '0;
      div_den   = den_sum;
      div_steps = hhi_pkg::GAS_STEPS;
    end else begin
      div_rem   = '0;
      div_num   = {1'b0, nk_r, 7'b0, 2'b00};
      div_den   = hhi_pkg::DIV_W'(g_eff);
      div_steps = hhi_pkg::LAYER_STEPS;
    end
  end

  assign log_start = (op == hhi_pkg::OP_LOG_BELOW) || (op == hhi_pkg::OP_LOG_CUR);
  assign log_value = (op == hhi_pkg::OP_LOG_BELOW) ? bpres_r : p_r;

  hhi_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .init_rem (div_rem),
    .init_num (div_num),
    .divisor  (div_den),
    .steps    (div_steps),
    .busy     (div_busy),
    .quotient (div_q)
  );

  hhi_log2 #(
    .LOG_ITERATIONS (LOG_ITERATIONS)
  ) u_log (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (log_start),
    .value  (log_value),
    .busy   (log_busy),
    .result (log_result)
  );

  assign ln_prod = 61'(mag_r[36:8]) * 61'(hhi_pkg::LN2_Q32);

  always_comb begin
    inner = 61'({a_r[1:0], 30'b0}) + 61'(b_r);
    dz    = 60'(a_r[60:2]) + 60'(inner[60:32]);
    dzc   = (dz > 60'h1000_0000) ? 29'h1000_0000 : dz[28:0];
    dmag  = $signed({1'b0, dzc});
    dsig  = neg_r ? -dmag : dmag;
    hsum  = 30'(bh_r) + dsig;
    if (start_r) begin
      h_nxt   = '0;
      bad_nxt = (p_r == '0);
    end else if (p_r == '0) begin
      h_nxt   = hhi_pkg::H_MAX;
      bad_nxt = 1'b1;
    end else if (bpres_r == '0) begin
      h_nxt   = hhi_pkg::H_MIN;
      bad_nxt = 1'b1;
    end else if (hsum > 30'(hhi_pkg::H_MAX)) begin
      h_nxt   = hhi_pkg::H_MAX;
      bad_nxt = 1'b1;
    end else if (hsum < 30'(hhi_pkg::H_MIN)) begin
      h_nxt   = hhi_pkg::H_MIN;
      bad_nxt = 1'b1;
    end else begin
      h_nxt   = hsum[hhi_pkg::H_W-1:0];
      bad_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r        <= hhi_pkg::DRY_RESET;
      rv_r        <= hhi_pkg::VAPOUR_RESET;
      g_r         <= hhi_pkg::GRAV_RESET;
      bgas_r      <= '0;
      btemp_r     <= '0;
      bpres_r     <= '0;
      bh_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hhi_pkg::CFG_DRY:    rd_r <= cfg_data[19:0];
          hhi_pkg::CFG_VAPOUR: rv_r <= cfg_data[19:0];
          hhi_pkg::CFG_GRAV:   g_r  <= cfg_data;
          default: ;
        endcase
      end
      if (op == hhi_pkg::OP_EMIT) begin
        out_valid_r <= 1'b1;
        out_h_r     <= h_r;
        out_bad_r   <= bad_r;
        bgas_r      <= gas_r;
        btemp_r     <= t_r;
        bpres_r     <= p_r;
        bh_r        <= h_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      hhi_pkg::OP_LOAD: begin
        p_r     <= in_pressure;
        t_r     <= in_temperature;
        x_r     <= in_water_vapour_ratio;
        start_r <= in_column_start;
      end
      hhi_pkg::OP_MUL_GAS: begin
        rdrv_r <= 40'(rd_r) * 40'(rv_r);
        dena_r <= 45'(25'h100_0000 - 25'(x_r)) * 45'(rv_r);
        denb_r <= 44'(x_r) * 44'(rd_r);
      end
      hhi_pkg::OP_DIV_GAS: begin
        den_zero_r <= (den_sum == '0);
      end
      hhi_pkg::OP_LOG_BELOW: begin
        gas_r <= den_zero_r ? '0 : div_q[hhi_pkg::GAS_W-1:0];
      end
      hhi_pkg::OP_LOG_CUR: begin
        lb_r <= log_result;
      end
      hhi_pkg::OP_MUL_SUM: begin
        lc_r <= log_result;
        pa_r <= 39'(bgas_r) * 39'(btemp_r);
        pb_r <= 39'(gas_r) * 39'(t_r);
      end
      hhi_pkg::OP_ADD_SUM: begin
        sum_r <= 40'(pa_r) + 40'(pb_r);
      end
      hhi_pkg::OP_MUL_K: begin
        nk_r <= 54'(sum_r) * 54'(hhi_pkg::SCALE_K);
      end
      hhi_pkg::OP_MAG: begin
        c_r   <= div_q[61:0];
        neg_r <= lc_r > lb_r;
        mag_r <= (lc_r > lb_r) ? lc_r - lb_r : lb_r - lc_r;
      end
      hhi_pkg::OP_LN: begin
        ln_r <= ln_prod[60:32];
      end
      hhi_pkg::OP_MUL_HI: begin
        a_r <= 61'(c_r[61:30]) * 61'(ln_r);
      end
      hhi_pkg::OP_MUL_LO: begin
        b_r <= 59'(c_r[29:0]) * 59'(ln_r);
      end
      hhi_pkg::OP_HEIGHT: begin
        h_r   <= h_nxt;
        bad_r <= bad_nxt;
      end
      default: ;
    endcase
  end

  assign status.div_busy = div_busy;
  assign status.log_busy = log_busy;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_height_mm = out_h_r;
  assign out_invalid   = out_bad_r;

endmodule

>>> hw/rtl/hhi_ctrl.sv
module hhi_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  hhi_pkg::status_t status,
  output hhi_pkg::op_t     op
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_MUL_GAS,
    S_DIV_GAS,
    S_DIV_GAS_WAIT,
    S_LOG_BELOW,
    S_LOG_BELOW_WAIT,
    S_LOG_CUR,
    S_LOG_CUR_WAIT,
    S_MUL_SUM,
    S_ADD_SUM,
    S_MUL_K,
    S_DIV_LAYER,
    S_DIV_LAYER_WAIT,
    S_MAG,
    S_LN,
    S_MUL_HI,
    S_MUL_LO,
    S_HEIGHT,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = hhi_pkg::OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = hhi_pkg::OP_LOAD;
          state_nxt = S_MUL_GAS;
        end
      end
      S_MUL_GAS: begin
        op        = hhi_pkg::OP_MUL_GAS;
        state_nxt = S_DIV_GAS;
      end
      S_DIV_GAS: begin
        op        = hhi_pkg::OP_DIV_GAS;
        state_nxt = S_DIV_GAS_WAIT;
      end
      S_DIV_GAS_WAIT: begin
        if (!status.div_busy) state_nxt = S_LOG_BELOW;
      end
      S_LOG_BELOW: begin
        op        = hhi_pkg::OP_LOG_BELOW;
        state_nxt = S_LOG_BELOW_WAIT;
      end
      S_LOG_BELOW_WAIT: begin
        if (!status.log_busy) state_nxt = S_LOG_CUR;
      end
      S_LOG_CUR: begin
        op        = hhi_pkg::OP_LOG_CUR;
        state_nxt = S_LOG_CUR_WAIT;
      end
      S_LOG_CUR_WAIT: begin
        if (!status.log_busy) state_nxt = S_MUL_SUM;
      end
      S_MUL_SUM: begin
        op        = hhi_pkg::OP_MUL_SUM;
        state_nxt = S_ADD_SUM;
      end
      S_ADD_SUM: begin
        op        = hhi_pkg::OP_ADD_SUM;
        state_nxt = S_MUL_K;
      end
      S_MUL_K: begin
        op        = hhi_pkg::OP_MUL_K;
        state_nxt = S_DIV_LAYER;
      end
      S_DIV_LAYER: begin
        op        = hhi_pkg::OP_DIV_LAYER;
        state_nxt = S_DIV_LAYER_WAIT;
      end
      S_DIV_LAYER_WAIT: begin
        if (!status.div_busy) state_nxt = S_MAG;
      end
      S_MAG: begin
        op        = hhi_pkg::OP_MAG;
        state_nxt = S_LN;
      end
      S_LN: begin
        op        = hhi_pkg::OP_LN;
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        op        = hhi_pkg::OP_MUL_HI;
        state_nxt = S_MUL_LO;
      end
      S_MUL_LO: begin
        op        = hhi_pkg::OP_MUL_LO;
        state_nxt = S_HEIGHT;
      end
      S_HEIGHT: begin
        op        = hhi_pkg::OP_HEIGHT;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          op        = hhi_pkg::OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
